@@ hw/rtl/elliptical_gaussian_ring_pixel_top_defines.svh @@
`ifndef ELLIPTICAL_GAUSSIAN_RING_PIXEL_TOP_DEFINES_SVH
`define ELLIPTICAL_GAUSSIAN_RING_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define EGR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("egr assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define EGR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("egr assertion failed");

`endif

@@ hw/rtl/egr_pkg.sv @@
package egr_pkg;

    localparam int EXP_TABLE_DEPTH_DEF = 1024;
    localparam int COORD_FRAC_BITS_DEF = 8;
    localparam int EXP_INT_SPAN        = 24;
    localparam int ISQ_STAGES          = 32;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X       = 4'd0,
        CFG_CENTER_Y       = 4'd1,
        CFG_COS_ANGLE      = 4'd2,
        CFG_SIN_ANGLE      = 4'd3,
        CFG_INV_AXIS_RATIO = 4'd4,
        CFG_AMPLITUDE      = 4'd5,
        CFG_RING_RADIUS    = 4'd6,
        CFG_INV_TWO_SIG_SQ = 4'd7
    } t_cfg_idx;

    // exp(-f), f scaled by 2^31, result Q1.31, Taylor series up to the 24th power, truncating terms
    function automatic logic [31:0] taylor_exp_neg(input logic [63:0] f);
        longint      sum;
        logic [63:0] t;
        sum = longint'(64'd1 << 31);
        t   = 64'd1 << 31;
        for (int k = 1; k <= 24; k++) begin
            t = ((t * f) >> 31) / 64'(k);
            if ((k % 2) == 1) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return sum[31:0];
    endfunction

    // exp(-n) in Q1.31 by repeated rounded multiply with exp(-1)
    function automatic logic [31:0] exp_int(input int n);
        logic [63:0] e1;
        logic [63:0] v;
        e1 = 64'(taylor_exp_neg(64'd1 << 31));
        v  = 64'd1 << 31;
        for (int i = 1; i <= n; i++) begin
            v = (v * e1 + (64'd1 << 30)) >> 31;
        end
        return v[31:0];
    endfunction

endpackage

@@ hw/rtl/egr_ram.sv @@
module egr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/egr_isqrt.sv @@
// Floor square root, one result bit per stage, MSB first.
module egr_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [62:0] i_val,
    output logic [31:0] o_root
);

    localparam int NS = egr_pkg::ISQ_STAGES;

    logic [63:0] r_rem  [NS];
    logic [31:0] r_root [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stg
        localparam int B = NS - 1 - j;
        logic [63:0] w_rem_in;
        logic [31:0] w_root_in;
        logic [63:0] w_cand;

        if (j == 0) begin : g_first
            assign w_rem_in  = {1'b0, i_val};
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_root_in = r_root[j-1];
        end

        // (root + 2^B)^2 - root^2
        assign w_cand = ({32'd0, w_root_in} << (B + 1)) + (64'd1 << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem_in >= w_cand) begin
                    r_rem[j]  <= w_rem_in - w_cand;
                    r_root[j] <= w_root_in | (32'd1 << B);
                end else begin
                    r_rem[j]  <= w_rem_in;
                    r_root[j] <= w_root_in;
                end
            end
        end
    end

    assign o_root = r_root[NS-1];

endmodule

@@ hw/rtl/elliptical_gaussian_ring_pixel_top.sv @@
// Elliptical Gaussian ring intensity, one pixel per request. Takes one pixel
// every cycle while the output is not stalled; the pipeline depth comes from
// the 32-stage square root pipeline plus 18 stages of multiply, round and
// table lookup. After reset the exp fraction table is loaded into its RAM,
// one entry a cycle, so no pixel is taken until the table is full;
// configuration writes are taken at any time but must only be made
// while the pipeline is empty. A stall on the output freezes the whole pipe.
module elliptical_gaussian_ring_pixel_top #(
    parameter int EXP_TABLE_DEPTH = egr_pkg::EXP_TABLE_DEPTH_DEF,
    parameter int COORD_FRAC_BITS = egr_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [47:0]                    i_s_tdata,   // [23:0] x_coord, [47:24] y_coord
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [31:0]                    o_m_tdata,   // [31:0] intensity
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [egr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [egr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    `include "elliptical_gaussian_ring_pixel_top_defines.svh"

    localparam int AW   = $clog2(EXP_TABLE_DEPTH);
    localparam int CW   = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int SH   = 2 * COORD_FRAC_BITS;
    localparam int NSTG = 18 + egr_pkg::ISQ_STAGES;
    localparam int SQ_V = 7 + egr_pkg::ISQ_STAGES;   // valid index at root output

    // configuration
    logic signed [23:0] r_center_x, r_center_y;
    logic signed [17:0] r_cos, r_sin;
    logic        [23:0] r_inv_q;
    logic        [31:0] r_amp;
    logic        [22:0] r_radius;
    logic        [31:0] r_inv_2s2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_cos      <= 18'sd65536;
            r_sin      <= '0;
            r_inv_q    <= 24'd65536;
            r_amp      <= 32'd65536;
            r_radius   <= '0;
            r_inv_2s2  <= 32'd16777216;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                egr_pkg::CFG_CENTER_X:       r_center_x <= i_cfg_data[23:0];
                egr_pkg::CFG_CENTER_Y:       r_center_y <= i_cfg_data[23:0];
                egr_pkg::CFG_COS_ANGLE:      r_cos      <= i_cfg_data[17:0];
                egr_pkg::CFG_SIN_ANGLE:      r_sin      <= i_cfg_data[17:0];
                egr_pkg::CFG_INV_AXIS_RATIO: r_inv_q    <= i_cfg_data[23:0];
                egr_pkg::CFG_AMPLITUDE:      r_amp      <= i_cfg_data;
                egr_pkg::CFG_RING_RADIUS:    r_radius   <= i_cfg_data[22:0];
                egr_pkg::CFG_INV_TWO_SIG_SQ: r_inv_2s2  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // exp fraction table load
    logic [31:0]   w_efrac_rom [EXP_TABLE_DEPTH];
    logic [CW-1:0] r_fill_cnt;
    logic          r_fill_done;

    for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
        localparam logic [31:0] V =
            egr_pkg::taylor_exp_neg((64'(i) << 31) / 64'(EXP_TABLE_DEPTH));
        assign w_efrac_rom[i] = V;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_cnt  <= '0;
            r_fill_done <= 1'b0;
        end else if (!r_fill_done) begin
            r_fill_cnt <= r_fill_cnt + 1'b1;
            if (r_fill_cnt == CW'(EXP_TABLE_DEPTH - 1)) begin
                r_fill_done <= 1'b1;
            end
        end
    end

    logic [31:0] w_eneg_rom [egr_pkg::EXP_INT_SPAN];
    for (genvar i = 0; i < egr_pkg::EXP_INT_SPAN; i++) begin : g_eneg
        localparam logic [31:0] V = egr_pkg::exp_int(i);
        assign w_eneg_rom[i] = V;
    end

    // pipeline control
    logic            w_en;
    logic [NSTG-1:0] r_vld;

    assign w_en       = !r_vld[NSTG-1] || i_m_tready;
    assign o_s_tready = w_en && r_fill_done;
    assign o_m_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_tvalid && r_fill_done};
        end
    end

    // datapath
    logic signed [24:0] r_dx, r_dy;
    logic signed [42:0] r_p_xc, r_p_ys, r_p_yc, r_p_xs;
    logic signed [43:0] r_xr, r_yr;
    logic        [28:0] r_xp4, r_yp4, r_xp5;
    logic        [52:0] r_ypm;
    logic        [30:0] r_yp;
    logic        [57:0] r_xsq, r_xsq7;
    logic        [61:0] r_ysq;
    logic        [62:0] r_sum;
    logic        [31:0] w_root;
    logic        [31:0] r_d;
    logic        [63:0] r_d2;
    logic        [63:0] r_plo, r_phi;
    logic        [63:0] r_top;
    logic        [31:0] r_bot;
    logic        [4:0]  r_n;
    logic        [AW-1:0] r_idx;
    logic        [31:0] r_eneg;
    logic        [31:0] w_efrac;
    logic        [63:0] r_eprod;
    logic        [31:0] r_e;
    logic        [63:0] r_aprod;
    logic        [31:0] r_out;
    logic               r_kill_e, r_kill_f, r_kill_g, r_kill_h, r_kill_i;

    logic [43:0] w_xmag, w_ymag;
    logic [44:0] w_xrnd, w_yrnd;
    logic [53:0] w_yrnd2;
    logic [60:0] w_u;
    logic [24+CW-1:0] w_idx_full;
    logic [CW-1:0]    w_idx;
    logic [64:0]      w_e_rnd, w_a_rnd;

    assign w_xmag  = r_xr[43] ? 44'(-r_xr) : 44'(r_xr);
    assign w_ymag  = r_yr[43] ? 44'(-r_yr) : 44'(r_yr);
    assign w_xrnd  = {1'b0, w_xmag} + 45'd32768;
    assign w_yrnd  = {1'b0, w_ymag} + 45'd32768;
    assign w_yrnd2 = {1'b0, r_ypm} + 54'd32768;

    assign w_u        = {r_top[28:0], r_bot} >> SH;
    assign w_idx_full = w_u[23:0] * CW'(EXP_TABLE_DEPTH);
    assign w_idx      = w_idx_full[24 +: CW];

    assign w_e_rnd = {1'b0, r_eprod} + 65'd1073741824;
    assign w_a_rnd = {1'b0, r_aprod} + 65'd1073741824;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= {i_s_tdata[23], i_s_tdata[23:0]} - {r_center_x[23], r_center_x};
            r_dy <= {i_s_tdata[47], i_s_tdata[47:24]} - {r_center_y[23], r_center_y};

            r_p_xc <= r_dx * r_cos;
            r_p_ys <= r_dy * r_sin;
            r_p_yc <= r_dy * r_cos;
            r_p_xs <= r_dx * r_sin;

            r_xr <= 44'(r_p_xc) + 44'(r_p_ys);
            r_yr <= 44'(r_p_yc) - 44'(r_p_xs);

            r_xp4 <= w_xrnd[44:16];
            r_yp4 <= w_yrnd[44:16];

            r_ypm <= r_yp4 * r_inv_q;
            r_xp5 <= r_xp4;

            r_yp  <= (w_yrnd2[53:47] != '0) ? 31'h7FFF_FFFF : w_yrnd2[46:16];
            r_xsq <= r_xp5 * r_xp5;

            r_ysq  <= r_yp * r_yp;
            r_xsq7 <= r_xsq;

            r_sum <= 63'(r_xsq7) + 63'(r_ysq);

            r_d <= (w_root >= 32'(r_radius)) ? w_root - 32'(r_radius)
                                             : 32'(r_radius) - w_root;

            r_d2 <= r_d * r_d;

            r_plo <= r_d2[31:0]  * r_inv_2s2;
            r_phi <= r_d2[63:32] * r_inv_2s2;

            r_top <= r_phi + {32'd0, r_plo[63:32]};
            r_bot <= r_plo[31:0];

            // far from ring: u too big or beyond the integer table
            r_kill_e <= (r_top[63:29] != '0) || (w_u[60:24] >= 37'(egr_pkg::EXP_INT_SPAN));
            r_n      <= w_u[28:24];
            r_idx    <= (w_idx >= CW'(EXP_TABLE_DEPTH)) ? AW'(EXP_TABLE_DEPTH - 1)
                                                        : w_idx[AW-1:0];

            r_eneg   <= (r_n < 5'(egr_pkg::EXP_INT_SPAN)) ? w_eneg_rom[r_n] : '0;
            r_kill_f <= r_kill_e;

            r_eprod  <= r_eneg * w_efrac;
            r_kill_g <= r_kill_f;

            r_e      <= w_e_rnd[62:31];
            r_kill_h <= r_kill_g;

            r_aprod  <= r_amp * r_e;
            r_kill_i <= r_kill_h;

            if (r_kill_i) begin
                r_out <= '0;
            end else if (w_a_rnd[64:63] != '0) begin
                r_out <= '1;
            end else begin
                r_out <= w_a_rnd[62:31];
            end
        end
    end

    egr_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_sum),
        .o_root (w_root)
    );

    egr_ram #(
        .WIDTH (32),
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_efrac_ram (
        .i_clk   (i_clk),
        .i_we    (!r_fill_done),
        .i_waddr (r_fill_cnt[AW-1:0]),
        .i_wdata (w_efrac_rom[r_fill_cnt[AW-1:0]]),
        .i_re    (w_en),
        .i_raddr (r_idx),
        .o_rdata (w_efrac)
    );

    assign o_m_tdata = r_out;

    `EGR_ASSERT_NOW(a_no_pixel_during_fill, i_s_tvalid && o_s_tready, r_fill_done)
    `EGR_ASSERT_NEXT(a_stall_freezes_pipe, !w_en, $stable(r_vld))
    `EGR_ASSERT_NOW(a_fill_cnt_bounded, 1'b1, r_fill_cnt <= CW'(EXP_TABLE_DEPTH))
    `EGR_ASSERT_NOW(a_root_stage_valid, r_vld[SQ_V] && !r_fill_done, 1'b0)

endmodule
